// ----- hdl/vt52_pkg.sv -----
// Shared package of the VT52 escape terminal engine.
// Holds screen geometry, drawing op codes, datapath actions and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package vt52_pkg;

  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_ROWS = 25;

  localparam int unsigned COL_W = 7;
  localparam int unsigned ROW_W = 5;
  localparam int unsigned OP_W  = 4;

  localparam logic [7:0] BIAS       = 8'd32;
  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

  // Drawing commands for the video backend.
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_PLOT       = 4'd1;
  localparam logic [OP_W-1:0] OP_ERASE_EOS  = 4'd2;
  localparam logic [OP_W-1:0] OP_ERASE_EOL  = 4'd3;
  localparam logic [OP_W-1:0] OP_ERASE_BOS  = 4'd4;
  localparam logic [OP_W-1:0] OP_ERASE_BOL  = 4'd5;
  localparam logic [OP_W-1:0] OP_ERASE_LINE = 4'd6;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd7;
  localparam logic [OP_W-1:0] OP_DELETE     = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd9;

  // Actions the datapath carries out for one result beat.
  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_PLOT,
    ACT_TAB_PLOT,
    ACT_CR,
    ACT_BS,
    ACT_LF,
    ACT_UP,
    ACT_DOWN,
    ACT_RIGHT,
    ACT_LEFT,
    ACT_HOME,
    ACT_CLEAR,
    ACT_REGION,
    ACT_SAVE,
    ACT_RESTORE,
    ACT_REV_ON,
    ACT_REV_OFF,
    ACT_WRAP_ON,
    ACT_WRAP_OFF,
    ACT_COLOR,
    ACT_Y_ROW,
    ACT_Y_COL
  } act_e;

  typedef struct packed {
    logic            load;
    act_e            act;
    logic [OP_W-1:0] region_op;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] tab_phase;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/vt52_ctrl.sv -----
// Controller of the VT52 engine: escape parser, tab expansion sequencer and
// output beat valid. Depends on vt52_pkg.
`default_nettype none

module vt52_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_byte_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  vt52_pkg::dp_stat_t stat_i,
  output vt52_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ESC  = 3'd1;
  localparam logic [2:0] ST_YROW = 3'd2;
  localparam logic [2:0] ST_YCOL = 3'd3;
  localparam logic [2:0] ST_BVAL = 3'd4;
  localparam logic [2:0] ST_SKIP = 3'd5;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic [7:0] CH_UP      = "A";
  localparam logic [7:0] CH_REV_LF  = "I";
  localparam logic [7:0] CH_DOWN    = "B";
  localparam logic [7:0] CH_RIGHT   = "C";
  localparam logic [7:0] CH_LEFT    = "D";
  localparam logic [7:0] CH_HOME    = "H";
  localparam logic [7:0] CH_CLEAR   = "E";
  localparam logic [7:0] CH_EOS     = "J";
  localparam logic [7:0] CH_EOL     = "K";
  localparam logic [7:0] CH_BOS     = "d";
  localparam logic [7:0] CH_BOL     = "o";
  localparam logic [7:0] CH_LINE    = "l";
  localparam logic [7:0] CH_INSERT  = "L";
  localparam logic [7:0] CH_DELETE  = "M";
  localparam logic [7:0] CH_SAVE    = "j";
  localparam logic [7:0] CH_RESTORE = "k";
  localparam logic [7:0] CH_REV_ON  = "p";
  localparam logic [7:0] CH_REV_OFF = "q";
  localparam logic [7:0] CH_WRAP_ON = "v";
  localparam logic [7:0] CH_WRAP_OF = "w";
  localparam logic [7:0] CH_DIRECT  = "Y";
  localparam logic [7:0] CH_COLOR   = "b";
  localparam logic [7:0] CH_SKIP    = "c";

  logic [2:0] state_q, state_d;
  logic [2:0] tab_left_q, tab_left_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (tab_left_q == 3'd0) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load      = 1'b0;
    cmd_o.act       = vt52_pkg::ACT_NOP;
    cmd_o.region_op = vt52_pkg::OP_NONE;
    cmd_o.last      = 1'b1;
    state_d         = state_q;
    tab_left_d      = tab_left_q;

    if (tab_left_q != 3'd0) begin
      if (slot_free) begin
        cmd_o.load = 1'b1;
        cmd_o.act  = vt52_pkg::ACT_TAB_PLOT;
        cmd_o.last = (tab_left_q == 3'd1);
        tab_left_d = tab_left_q - 3'd1;
      end
    end else if (accept) begin
      cmd_o.load = 1'b1;
      state_d    = ST_IDLE;
      unique case (state_q)
        ST_ESC: begin
          unique case (char_byte_i)
            CH_DIRECT:  state_d = ST_YROW;
            CH_COLOR:   state_d = ST_BVAL;
            CH_SKIP:    state_d = ST_SKIP;
            CH_UP,
            CH_REV_LF:  cmd_o.act = vt52_pkg::ACT_UP;
            CH_DOWN:    cmd_o.act = vt52_pkg::ACT_DOWN;
            CH_RIGHT:   cmd_o.act = vt52_pkg::ACT_RIGHT;
            CH_LEFT:    cmd_o.act = vt52_pkg::ACT_LEFT;
            CH_HOME:    cmd_o.act = vt52_pkg::ACT_HOME;
            CH_CLEAR:   cmd_o.act = vt52_pkg::ACT_CLEAR;
            CH_EOS: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_ERASE_EOS;
            end
            CH_EOL: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_ERASE_EOL;
            end
            CH_BOS: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_ERASE_BOS;
            end
            CH_BOL: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_ERASE_BOL;
            end
            CH_LINE: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_ERASE_LINE;
            end
            CH_INSERT: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_INSERT;
            end
            CH_DELETE: begin
              cmd_o.act       = vt52_pkg::ACT_REGION;
              cmd_o.region_op = vt52_pkg::OP_DELETE;
            end
            CH_SAVE:    cmd_o.act = vt52_pkg::ACT_SAVE;
            CH_RESTORE: cmd_o.act = vt52_pkg::ACT_RESTORE;
            CH_REV_ON:  cmd_o.act = vt52_pkg::ACT_REV_ON;
            CH_REV_OFF: cmd_o.act = vt52_pkg::ACT_REV_OFF;
            CH_WRAP_ON: cmd_o.act = vt52_pkg::ACT_WRAP_ON;
            CH_WRAP_OF: cmd_o.act = vt52_pkg::ACT_WRAP_OFF;
            default:    cmd_o.act = vt52_pkg::ACT_NOP;
          endcase
        end
        ST_YROW: begin
          cmd_o.act = vt52_pkg::ACT_Y_ROW;
          state_d   = ST_YCOL;
        end
        ST_YCOL: cmd_o.act = vt52_pkg::ACT_Y_COL;
        ST_BVAL: cmd_o.act = vt52_pkg::ACT_COLOR;
        ST_SKIP: cmd_o.act = vt52_pkg::ACT_NOP;
        default: begin
          unique case (char_byte_i)
            CH_ESC: state_d   = ST_ESC;
            CH_CR:  cmd_o.act = vt52_pkg::ACT_CR;
            CH_BS:  cmd_o.act = vt52_pkg::ACT_BS;
            CH_LF:  cmd_o.act = vt52_pkg::ACT_LF;
            CH_TAB: begin
              // First space goes out now, the rest up to the next tab stop follow.
              cmd_o.act  = vt52_pkg::ACT_TAB_PLOT;
              cmd_o.last = (stat_i.tab_phase == 3'h7);
              tab_left_d = ~stat_i.tab_phase;
            end
            default: cmd_o.act = vt52_pkg::ACT_PLOT;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tab_left_q  <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_left_q  <= tab_left_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vt52_datapath.sv -----
// Datapath of the VT52 engine: cursor, saved cursor, mode flags, color and
// the registered result beat. Depends on vt52_pkg.
`default_nettype none

module vt52_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [7:0]                          char_byte_i,
  input  vt52_pkg::dp_cmd_t                   cmd_i,
  output vt52_pkg::dp_stat_t                  stat_o,
  output logic [vt52_pkg::OP_W-1:0]           op_o,
  output logic [7:0]                          glyph_code_o,
  output logic [vt52_pkg::COL_W-1:0]          cell_col_o,
  output logic [vt52_pkg::ROW_W-1:0]          cell_row_o,
  output logic                                invert_o,
  output logic [1:0]                          ink_color_o,
  output logic [vt52_pkg::COL_W-1:0]          new_cursor_col_o,
  output logic [vt52_pkg::ROW_W-1:0]          new_cursor_row_o,
  output logic                                last_o
);

  logic [vt52_pkg::COL_W-1:0] col_q, col_d, saved_col_q, saved_col_d;
  logic [vt52_pkg::ROW_W-1:0] row_q, row_d, saved_row_q, saved_row_d;
  logic                       wrap_q, wrap_d, rev_q, rev_d;
  logic [1:0]                 color_q, color_d;
  logic [7:0]                 pend_q, pend_d;

  logic [vt52_pkg::OP_W-1:0]  op_d;
  logic [7:0]                 glyph_d;
  logic [vt52_pkg::COL_W-1:0] cell_col_d;
  logic [vt52_pkg::ROW_W-1:0] cell_row_d;
  logic                       inv_d;

  logic [vt52_pkg::COL_W:0]   col_inc;
  logic [vt52_pkg::ROW_W:0]   row_inc;
  logic [vt52_pkg::ROW_W-1:0] row_next;
  logic [vt52_pkg::COL_W-1:0] plot_col;
  logic [vt52_pkg::ROW_W-1:0] plot_row;
  logic [7:0]                 y_row_raw, y_col_raw;
  logic [vt52_pkg::ROW_W-1:0] y_row;
  logic [vt52_pkg::COL_W-1:0] y_col;

  assign stat_o.tab_phase = col_q[2:0];

  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_next = (row_inc >= (vt52_pkg::ROW_W + 1)'(vt52_pkg::SCREEN_ROWS)) ?
                    '0 : row_inc[vt52_pkg::ROW_W-1:0];

  // Cursor after a glyph plot: wrap to the next line or stick at the margin.
  always_comb begin
    plot_col = col_inc[vt52_pkg::COL_W-1:0];
    plot_row = row_q;
    if (col_inc >= (vt52_pkg::COL_W + 1)'(vt52_pkg::SCREEN_COLS)) begin
      if (wrap_q) begin
        plot_col = '0;
        plot_row = row_next;
      end else begin
        plot_col = vt52_pkg::LAST_COL;
      end
    end
  end

  // Direct cursor address: remove the bias, then clamp to the screen.
  assign y_row_raw = (pend_q >= vt52_pkg::BIAS) ? pend_q - vt52_pkg::BIAS : 8'd0;
  assign y_col_raw = (char_byte_i >= vt52_pkg::BIAS) ? char_byte_i - vt52_pkg::BIAS : 8'd0;
  assign y_row = (y_row_raw >= 8'(vt52_pkg::SCREEN_ROWS)) ?
                 vt52_pkg::LAST_ROW : y_row_raw[vt52_pkg::ROW_W-1:0];
  assign y_col = (y_col_raw >= 8'(vt52_pkg::SCREEN_COLS)) ?
                 vt52_pkg::LAST_COL : y_col_raw[vt52_pkg::COL_W-1:0];

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    saved_col_d = saved_col_q;
    saved_row_d = saved_row_q;
    wrap_d      = wrap_q;
    rev_d       = rev_q;
    color_d     = color_q;
    pend_d      = pend_q;
    op_d        = vt52_pkg::OP_NONE;
    glyph_d     = 8'd0;
    cell_col_d  = '0;
    cell_row_d  = '0;
    inv_d       = 1'b0;

    unique case (cmd_i.act)
      vt52_pkg::ACT_PLOT, vt52_pkg::ACT_TAB_PLOT: begin
        op_d       = vt52_pkg::OP_PLOT;
        glyph_d    = (cmd_i.act == vt52_pkg::ACT_PLOT) ? char_byte_i : vt52_pkg::SPACE_CODE;
        cell_col_d = col_q;
        cell_row_d = row_q;
        inv_d      = rev_q;
        col_d      = plot_col;
        row_d      = plot_row;
      end
      vt52_pkg::ACT_CR: col_d = '0;
      vt52_pkg::ACT_BS: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end
      end
      vt52_pkg::ACT_LF: begin
        col_d = '0;
        row_d = row_next;
      end
      vt52_pkg::ACT_UP: begin
        if (row_q != '0) begin
          row_d = row_q - 1'b1;
        end
      end
      vt52_pkg::ACT_DOWN: begin
        if (row_inc < (vt52_pkg::ROW_W + 1)'(vt52_pkg::SCREEN_ROWS)) begin
          row_d = row_inc[vt52_pkg::ROW_W-1:0];
        end
      end
      vt52_pkg::ACT_RIGHT: begin
        if (col_inc < (vt52_pkg::COL_W + 1)'(vt52_pkg::SCREEN_COLS)) begin
          col_d = col_inc[vt52_pkg::COL_W-1:0];
        end
      end
      vt52_pkg::ACT_LEFT: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end
      end
      vt52_pkg::ACT_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      vt52_pkg::ACT_CLEAR: begin
        op_d  = vt52_pkg::OP_CLEAR;
        rev_d = 1'b0;
        col_d = '0;
        row_d = '0;
      end
      vt52_pkg::ACT_REGION: begin
        op_d       = cmd_i.region_op;
        cell_col_d = col_q;
        cell_row_d = row_q;
      end
      vt52_pkg::ACT_SAVE: begin
        saved_col_d = col_q;
        saved_row_d = row_q;
      end
      vt52_pkg::ACT_RESTORE: begin
        col_d = saved_col_q;
        row_d = saved_row_q;
      end
      vt52_pkg::ACT_REV_ON:   rev_d   = 1'b1;
      vt52_pkg::ACT_REV_OFF:  rev_d   = 1'b0;
      vt52_pkg::ACT_WRAP_ON:  wrap_d  = 1'b1;
      vt52_pkg::ACT_WRAP_OFF: wrap_d  = 1'b0;
      vt52_pkg::ACT_COLOR:    color_d = char_byte_i[1:0];
      vt52_pkg::ACT_Y_ROW:    pend_d  = char_byte_i;
      vt52_pkg::ACT_Y_COL: begin
        col_d = y_col;
        row_d = y_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      saved_col_q <= '0;
      saved_row_q <= '0;
      wrap_q      <= 1'b1;
      rev_q       <= 1'b0;
      color_q     <= 2'd1;
      pend_q      <= 8'd0;
    end else if (cmd_i.load) begin
      col_q       <= col_d;
      row_q       <= row_d;
      saved_col_q <= saved_col_d;
      saved_row_q <= saved_row_d;
      wrap_q      <= wrap_d;
      rev_q       <= rev_d;
      color_q     <= color_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_o             <= op_d;
      glyph_code_o     <= glyph_d;
      cell_col_o       <= cell_col_d;
      cell_row_o       <= cell_row_d;
      invert_o         <= inv_d;
      ink_color_o      <= color_d;
      new_cursor_col_o <= col_d;
      new_cursor_row_o <= row_d;
      last_o           <= cmd_i.last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vt52_escape_terminal_engine.sv -----
// Each accepted byte has its first result beat registered as the byte is accepted.
// Throughput: one byte per cycle while the result side keeps up; a tab of n spaces
// holds the input for the n - 1 plots after its first (zero to seven).
// A waiting result blocks the next byte; a byte is accepted in the cycle the result drains.
// Reset (rst_ni low, asynchronous): parser idle, cursor and saved cursor home,
// wrap on, reverse off, color 1, no result pending.
`default_nettype none

// Top level of the VT52 escape terminal engine. Depends on vt52_pkg,
// vt52_ctrl and vt52_datapath.
//
// Each input beat carries one byte of a terminal stream. The controller
// tracks the escape parser (plain text, ESC seen, direct cursor row and
// column, color byte, swallowed byte) and turns every byte into one action,
// or, for a tab, into a run of space plots up to the next multiple of eight.
// The datapath holds the cursor and mode state and registers the drawing
// command that forms each output beat. The last flag marks the final beat
// caused by a byte; only tab produces more than one.
module vt52_escape_terminal_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          char_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vt52_pkg::OP_W-1:0]           op_o,
  output logic [7:0]                          glyph_code_o,
  output logic [vt52_pkg::COL_W-1:0]          cell_col_o,
  output logic [vt52_pkg::ROW_W-1:0]          cell_row_o,
  output logic                                invert_o,
  output logic [1:0]                          ink_color_o,
  output logic [vt52_pkg::COL_W-1:0]          new_cursor_col_o,
  output logic [vt52_pkg::ROW_W-1:0]          new_cursor_row_o,
  output logic                                last_o
);

  vt52_pkg::dp_cmd_t  cmd;
  vt52_pkg::dp_stat_t stat;

  // The controller issues at most one command per cycle, and only when the
  // output register is empty or is being drained in the same cycle.
  vt52_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath updates cursor state and loads the result registers on
  // every command; tab plots read the live cursor, so wraps land correctly.
  vt52_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_byte_i      (char_byte_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_o             (op_o),
    .glyph_code_o     (glyph_code_o),
    .cell_col_o       (cell_col_o),
    .cell_row_o       (cell_row_o),
    .invert_o         (invert_o),
    .ink_color_o      (ink_color_o),
    .new_cursor_col_o (new_cursor_col_o),
    .new_cursor_row_o (new_cursor_row_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ----- hdl/vt52_checker.sv -----
// Port-level checker for the VT52 engine, bound to the top level.
// Depends on vt52_pkg.
`default_nettype none

module vt52_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [vt52_pkg::OP_W-1:0]  op_o,
  input logic [7:0]                 glyph_code_o,
  input logic [vt52_pkg::COL_W-1:0] cell_col_o,
  input logic [vt52_pkg::ROW_W-1:0] cell_row_o,
  input logic [vt52_pkg::COL_W-1:0] new_cursor_col_o,
  input logic [vt52_pkg::ROW_W-1:0] new_cursor_row_o,
  input logic                       last_o
);

  // A stalled result beat keeps its command.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(op_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // The cursor never leaves the screen.
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_cursor_col_o <= vt52_pkg::LAST_COL &&
                    new_cursor_row_o <= vt52_pkg::LAST_ROW)
    else $error("cursor off screen");

  // Only plots carry multi-beat runs; every other command ends its byte.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_o != vt52_pkg::OP_PLOT |-> last_o && glyph_code_o == 8'd0)
    else $error("non-plot beat is not a single final beat");

  // Clear screen homes the cursor and addresses no cell.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_o == vt52_pkg::OP_CLEAR |->
      new_cursor_col_o == '0 && new_cursor_row_o == '0 &&
      cell_col_o == '0 && cell_row_o == '0)
    else $error("clear screen did not home the cursor");

endmodule

bind vt52_escape_terminal_engine vt52_checker u_vt52_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .op_o             (op_o),
  .glyph_code_o     (glyph_code_o),
  .cell_col_o       (cell_col_o),
  .cell_row_o       (cell_row_o),
  .new_cursor_col_o (new_cursor_col_o),
  .new_cursor_row_o (new_cursor_row_o),
  .last_o           (last_o)
);

`default_nettype wire
